// ===== src/svs_pkg.sv =====
// Types and constants for the searchable variable stack.
// Shared by the controller, the datapath and the top level; no dependencies.
package svs_pkg;

    localparam int LETTER_W = 8;
    localparam int SUB_W    = 15;
    localparam int OSUB_W   = 16;
    localparam int ENTRY_W  = LETTER_W + SUB_W;
    localparam int DEPTH_W  = 7;

    // Operation codes carried in the kind field
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;
    localparam logic [1:0] KIND_SEARCH = 2'd3;

    // Result selection codes from controller to datapath
    localparam logic [1:0] RS_PLAIN     = 2'd0;
    localparam logic [1:0] RS_OVERFLOW  = 2'd1;
    localparam logic [1:0] RS_UNDERFLOW = 2'd2;
    localparam logic [1:0] RS_ENTRY     = 2'd3;

    localparam logic signed [OSUB_W-1:0] ERR_SUBSCRIPT = -16'sd1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [LETTER_W-1:0] letter;
        logic [SUB_W-1:0]    subscript;
    } item_t;

    typedef struct packed {
        logic [LETTER_W-1:0]        out_letter;
        logic signed [OSUB_W-1:0]   out_subscript;
        logic                       found;
        logic                       error;
        logic                       is_empty;
        logic [DEPTH_W-1:0]         depth;
    } result_t;

    typedef struct packed {
        logic       take;     // latch the item for a pop, peek or search
        logic       wr;       // push: write entry, advance count
        logic       rd_top;   // read the top entry
        logic       rd_next;  // read the entry below the scan index
        logic       dec;      // pop: drop the top entry
        logic       load;     // load the result register
        logic [1:0] rsel;
        logic       found;
    } svs_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic match;
        logic idx_zero;
        logic is_pop;
        logic out_free;
    } svs_stat_t;

endpackage

// ===== src/svs_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module svs_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/svs_ctrl.sv =====
// Controller state machine for the searchable variable stack.
// Depends on svs_pkg; drives commands to svs_dp and reads its status.
module svs_ctrl
    import svs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic [1:0] item_kind,
    input  svs_stat_t  stat,
    output logic       item_stall,
    output svs_cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign item_stall = (state_reg != ST_IDLE) || !stat.out_free;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.rsel   = RS_PLAIN;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_kind)
                        KIND_PUSH:
                        begin
                            cmd.load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.rsel = RS_OVERFLOW;
                            end
                            else
                            begin
                                cmd.wr = 1'b1;
                            end
                        end
                        KIND_POP, KIND_PEEK:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load = 1'b1;
                                cmd.rsel = RS_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.take   = 1'b1;
                                cmd.rd_top = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load = 1'b1;
                            end
                            else
                            begin
                                cmd.take   = 1'b1;
                                cmd.rd_top = 1'b1;
                                state_next = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    cmd.rsel   = RS_ENTRY;
                    cmd.dec    = stat.is_pop;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (stat.match || stat.idx_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.load   = 1'b1;
                        cmd.found  = stat.match;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/svs_dp.sv =====
// Datapath for the searchable variable stack: entry memory, count, scan
// index and result register. Depends on svs_pkg and svs_ram.
module svs_dp
    import svs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  item_t     item,
    input  svs_cmd_t  cmd,
    input  logic      result_stall,
    output svs_stat_t stat,
    output logic      result_valid,
    output result_t   result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      count_m1;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      idx_next;
    logic [AW-1:0]      idx_m1;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic [ENTRY_W-1:0] item_var;
    logic [ENTRY_W-1:0] var_reg;
    logic [ENTRY_W-1:0] rd_data;
    logic               pop_reg;
    result_t            res_reg;
    result_t            res_next;
    logic               res_valid_reg;
    logic               res_valid_next;

    assign item_var = {item.letter, item.subscript};
    assign count_m1 = count_reg - CW'(1);
    assign idx_m1   = idx_reg - AW'(1);
    assign rd_en    = cmd.rd_top || cmd.rd_next;
    assign rd_addr  = cmd.rd_top ? count_m1[AW-1:0] : idx_m1;

    svs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (item_var),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.dec)
        begin
            count_next = count_m1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.rd_top)
        begin
            idx_next = count_m1[AW-1:0];
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_m1;
        end
    end

    always_comb
    begin
        res_next               = '0;
        res_next.found         = cmd.found;
        res_next.is_empty      = (count_next == '0);
        res_next.depth         = DEPTH_W'(count_next);
        case (cmd.rsel)
            RS_PLAIN:
            begin
                res_next.error = 1'b0;
            end
            RS_OVERFLOW:
            begin
                res_next.error = 1'b1;
            end
            RS_UNDERFLOW:
            begin
                res_next.error         = 1'b1;
                res_next.out_subscript = ERR_SUBSCRIPT;
            end
            RS_ENTRY:
            begin
                res_next.out_letter    = rd_data[ENTRY_W-1 -: LETTER_W];
                res_next.out_subscript = {1'b0, rd_data[SUB_W-1:0]};
            end
            default:
            begin
                res_next.error = 1'b0;
            end
        endcase
    end

    assign res_valid_next = cmd.load || (res_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.take)
        begin
            var_reg <= item_var;
            pop_reg <= (item.kind == KIND_POP);
        end
        if (cmd.load)
        begin
            res_reg <= res_next;
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.match    = (rd_data == var_reg);
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.is_pop   = pop_reg;
    assign stat.out_free = !res_valid_reg || !result_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== src/searchable_variable_stack_unit.sv =====
// Top level of the searchable variable stack: a bounded LIFO of variables
// with push, pop, peek and top-down search. Depends on svs_pkg, svs_ctrl,
// svs_dp (and through it svs_ram).
//
//  channel   direction  handshake                     payload
//  item      in         item_valid / item_stall       item_t   (kind, letter, subscript)
//  result    out        result_valid / result_stall   result_t (one per transaction)
//
// Push and any operation on an empty stack show their result the cycle after accept.
// Pop and peek read the top entry (the memory read port is registered), then load
// it into the result register once the output is free. Search reads one entry per
// cycle from the top down until a match or the bottom, then loads its result.
// Reset empties the stack at once (count cleared); the memory is not cleared.
// A waiting result is held in the output register; item_stall stays high
// while an operation is in progress or the held result is not being taken.
module searchable_variable_stack_unit
    import svs_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    svs_cmd_t  cmd;
    svs_stat_t stat;

    // Sequence each transaction: ops finished at accept, top read, or the scan.
    svs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_kind  (item.kind),
        .stat       (stat),
        .item_stall (item_stall),
        .cmd        (cmd)
    );

    // Hold the entries, the count, the scan index and the result register.
    svs_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .result_stall (result_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

`ifndef ASSERT_OFF
    // An accepted push always produces its result in the next cycle.
    a_push_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item.kind == KIND_PUSH) |=> result_valid)
        else $error("push result not produced in one cycle");

    // A search hit never reports an error.
    a_found_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.found) |-> !result.error)
        else $error("found result flagged as error");

    // The error subscript only appears on an underflow of an empty stack.
    a_err_var_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.out_subscript == ERR_SUBSCRIPT)
            |-> (result.error && result.is_empty && result.out_letter == '0))
        else $error("error variable returned from a non-empty stack");
`endif

endmodule
